FILE: hw/rtl/prime_partition_counter_core_macros.svh
// Assertion helpers for the core RTL file.
`ifndef PRIME_PARTITION_COUNTER_CORE_MACROS_SVH
`define PRIME_PARTITION_COUNTER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PPC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PPC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/ppc_pkg.sv
package ppc_pkg;

	localparam int TABLE_SIZE_DEF = 1024;
	localparam int CFG_W          = 11;
	localparam int COUNT_W        = 30;
	localparam int STATUS_W       = 2;
	localparam int PC_W           = 4;

	localparam logic [CFG_W-1:0]   LIMIT_RESET = 11'd1024;
	localparam logic [COUNT_W-1:0] COUNT_MOD   = 30'd1000000007;

	localparam logic OP_BUILD = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_ABOVE_LIMIT = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NOT_BUILT   = 2'd2;

	// Program steps
	localparam logic [PC_W-1:0] STEP_WAIT      = 4'd0;
	localparam logic [PC_W-1:0] STEP_INIT      = 4'd1;
	localparam logic [PC_W-1:0] STEP_CLEAR     = 4'd2;
	localparam logic [PC_W-1:0] STEP_SV_INIT   = 4'd3;
	localparam logic [PC_W-1:0] STEP_SV_READ   = 4'd4;
	localparam logic [PC_W-1:0] STEP_SV_TEST   = 4'd5;
	localparam logic [PC_W-1:0] STEP_SV_SKIP   = 4'd6;
	localparam logic [PC_W-1:0] STEP_SV_MARK   = 4'd7;
	localparam logic [PC_W-1:0] STEP_SV_NEXT   = 4'd8;
	localparam logic [PC_W-1:0] STEP_DP_INIT   = 4'd9;
	localparam logic [PC_W-1:0] STEP_DP_READ   = 4'd10;
	localparam logic [PC_W-1:0] STEP_DP_SKIP   = 4'd11;
	localparam logic [PC_W-1:0] STEP_DP_CNT_RD = 4'd12;
	localparam logic [PC_W-1:0] STEP_DP_CNT_WR = 4'd13;
	localparam logic [PC_W-1:0] STEP_DP_NEXT   = 4'd14;
	localparam logic [PC_W-1:0] STEP_DONE      = 4'd15;

	typedef enum logic [2:0] {
		J_HOLD,
		J_ZERO,
		J_INC,
		J_ADD_I,
		J_LOAD_SQ,
		J_LOAD_I
	} j_op_t;

	typedef enum logic [1:0] {
		I_HOLD,
		I_TWO,
		I_INC
	} i_op_t;

	typedef enum logic [2:0] {
		M_NONE,
		M_CLEAR,
		M_FLAG_RD,
		M_FLAG_SET,
		M_COUNT_RD,
		M_COUNT_WR
	} mem_op_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_START,
		C_J_LT_LIM,
		C_JI_LE_LIM,
		C_SQ_GT_LIM,
		C_FLAG,
		C_I_GT_LIM
	} cond_t;

	typedef struct packed {
		j_op_t            j_op;
		i_op_t            i_op;
		mem_op_t          mem_op;
		cond_t            cond;
		logic [PC_W-1:0]  target;
		logic             done;
	} ctrl_t;

	typedef struct packed {
		logic j_lt_lim;
		logic ji_le_lim;
		logic sq_gt_lim;
		logic i_gt_lim;
		logic flag;
	} dp_stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BUILD,
		ST_QUERY,
		ST_RESULT
	} state_t;

	// Control store: one word per step
	function automatic ctrl_t ppc_rom(input logic [PC_W-1:0] pc);
		ctrl_t c;
		c        = '0;
		c.j_op   = J_HOLD;
		c.i_op   = I_HOLD;
		c.mem_op = M_NONE;
		c.cond   = C_NEVER;
		case (pc)
			STEP_WAIT: begin
				c.cond   = C_NO_START;
				c.target = STEP_WAIT;
			end
			STEP_INIT: begin
				c.j_op = J_ZERO;
			end
			STEP_CLEAR: begin
				c.mem_op = M_CLEAR;
				c.j_op   = J_INC;
				c.cond   = C_J_LT_LIM;
				c.target = STEP_CLEAR;
			end
			STEP_SV_INIT: begin
				c.i_op = I_TWO;
			end
			STEP_SV_READ: begin
				c.mem_op = M_FLAG_RD;
			end
			STEP_SV_TEST: begin
				c.cond   = C_SQ_GT_LIM;
				c.target = STEP_DP_INIT;
			end
			STEP_SV_SKIP: begin
				c.j_op   = J_LOAD_SQ;
				c.cond   = C_FLAG;
				c.target = STEP_SV_NEXT;
			end
			STEP_SV_MARK: begin
				c.mem_op = M_FLAG_SET;
				c.j_op   = J_ADD_I;
				c.cond   = C_JI_LE_LIM;
				c.target = STEP_SV_MARK;
			end
			STEP_SV_NEXT: begin
				c.i_op   = I_INC;
				c.cond   = C_ALWAYS;
				c.target = STEP_SV_READ;
			end
			STEP_DP_INIT: begin
				c.i_op = I_TWO;
			end
			STEP_DP_READ: begin
				c.mem_op = M_FLAG_RD;
				c.cond   = C_I_GT_LIM;
				c.target = STEP_DONE;
			end
			STEP_DP_SKIP: begin
				c.j_op   = J_LOAD_I;
				c.cond   = C_FLAG;
				c.target = STEP_DP_NEXT;
			end
			STEP_DP_CNT_RD: begin
				c.mem_op = M_COUNT_RD;
			end
			STEP_DP_CNT_WR: begin
				c.mem_op = M_COUNT_WR;
				c.j_op   = J_INC;
				c.cond   = C_J_LT_LIM;
				c.target = STEP_DP_CNT_RD;
			end
			STEP_DP_NEXT: begin
				c.i_op   = I_INC;
				c.cond   = C_ALWAYS;
				c.target = STEP_DP_READ;
			end
			STEP_DONE: begin
				c.done   = 1'b1;
				c.cond   = C_ALWAYS;
				c.target = STEP_WAIT;
			end
			default: begin
				c.cond   = C_ALWAYS;
				c.target = STEP_WAIT;
			end
		endcase
		return c;
	endfunction

endpackage

FILE: hw/rtl/ppc_seq.sv
module ppc_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  ppc_pkg::dp_stat_t stat,
	output ppc_pkg::ctrl_t    ctrl,
	output logic              busy,
	output logic              done
);

	logic [ppc_pkg::PC_W-1:0] pc_q;
	logic [ppc_pkg::PC_W-1:0] pc_d;
	logic                     take;

	assign ctrl = ppc_pkg::ppc_rom(pc_q);
	assign busy = (pc_q != ppc_pkg::STEP_WAIT);
	assign done = ctrl.done;

	always_comb begin
		case (ctrl.cond)
			ppc_pkg::C_NEVER:     take = 1'b0;
			ppc_pkg::C_ALWAYS:    take = 1'b1;
			ppc_pkg::C_NO_START:  take = !start;
			ppc_pkg::C_J_LT_LIM:  take = stat.j_lt_lim;
			ppc_pkg::C_JI_LE_LIM: take = stat.ji_le_lim;
			ppc_pkg::C_SQ_GT_LIM: take = stat.sq_gt_lim;
			ppc_pkg::C_FLAG:      take = stat.flag;
			ppc_pkg::C_I_GT_LIM:  take = stat.i_gt_lim;
			default:              take = 1'b0;
		endcase
		pc_d = take ? ctrl.target : pc_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ppc_pkg::STEP_WAIT;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule

FILE: hw/rtl/ppc_dpath.sv
module ppc_dpath #(
	parameter int TABLE_SIZE = ppc_pkg::TABLE_SIZE_DEF,
	localparam int LIM_MAX   = (1 << ppc_pkg::CFG_W) - 1,
	localparam int DEPTH     = ((TABLE_SIZE < LIM_MAX) ? TABLE_SIZE : LIM_MAX) + 1,
	localparam int AW        = $clog2(DEPTH)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ppc_pkg::ctrl_t                   ctrl,
	input  logic [AW-1:0]                    lim,
	input  logic                             q_rd_en,
	input  logic [AW-1:0]                    q_addr,
	output logic [ppc_pkg::COUNT_W-1:0]      q_data,
	output ppc_pkg::dp_stat_t                stat
);

	localparam int CW      = AW + 1;

	logic [CW-1:0]                 i_q;
	logic [CW-1:0]                 j_q;
	logic [2*CW-1:0]               sq_q;
	logic [CW:0]                   ji_sum;
	logic                          flag_rd_q;
	logic [ppc_pkg::COUNT_W-1:0]   rd_a_q;
	logic [ppc_pkg::COUNT_W-1:0]   rd_b_q;
	logic [ppc_pkg::COUNT_W:0]     mod_sum;
	logic [ppc_pkg::COUNT_W-1:0]   mod_res;
	logic [AW-1:0]                 j_addr;
	logic [AW-1:0]                 i_addr;
	logic [AW-1:0]                 jm_addr;

	logic                          flag_mem [DEPTH];
	logic [ppc_pkg::COUNT_W-1:0]   cnt_mem  [DEPTH];

	assign j_addr  = j_q[AW-1:0];
	assign i_addr  = i_q[AW-1:0];
	assign jm_addr = AW'(j_q - i_q);
	assign ji_sum  = {1'b0, j_q} + {1'b0, i_q};

	assign stat.j_lt_lim  = (j_q < {1'b0, lim});
	assign stat.ji_le_lim = (ji_sum <= (CW + 1)'(lim));
	assign stat.sq_gt_lim = (sq_q > (2 * CW)'(lim));
	assign stat.i_gt_lim  = (i_q > {1'b0, lim});
	assign stat.flag      = flag_rd_q;

	// Add modulo the prime; both operands are already reduced
	always_comb begin
		mod_sum = {1'b0, rd_a_q} + {1'b0, rd_b_q};
		if (mod_sum >= {1'b0, ppc_pkg::COUNT_MOD}) begin
			mod_res = ppc_pkg::COUNT_W'(mod_sum - {1'b0, ppc_pkg::COUNT_MOD});
		end else begin
			mod_res = mod_sum[ppc_pkg::COUNT_W-1:0];
		end
	end

	assign q_data = rd_a_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q  <= '0;
			j_q  <= '0;
			sq_q <= '0;
		end else begin
			sq_q <= (2 * CW)'(i_q) * (2 * CW)'(i_q);
			case (ctrl.i_op)
				ppc_pkg::I_TWO: i_q <= CW'(2);
				ppc_pkg::I_INC: i_q <= i_q + 1'b1;
				default:        i_q <= i_q;
			endcase
			case (ctrl.j_op)
				ppc_pkg::J_ZERO:    j_q <= '0;
				ppc_pkg::J_INC:     j_q <= j_q + 1'b1;
				ppc_pkg::J_ADD_I:   j_q <= ji_sum[CW-1:0];
				ppc_pkg::J_LOAD_SQ: j_q <= sq_q[CW-1:0];
				ppc_pkg::J_LOAD_I:  j_q <= i_q;
				default:            j_q <= j_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.mem_op == ppc_pkg::M_CLEAR) begin
			flag_mem[j_addr] <= (j_q < CW'(2));
		end else if (ctrl.mem_op == ppc_pkg::M_FLAG_SET) begin
			flag_mem[j_addr] <= 1'b1;
		end
		if (ctrl.mem_op == ppc_pkg::M_FLAG_RD) begin
			flag_rd_q <= flag_mem[i_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.mem_op == ppc_pkg::M_CLEAR) begin
			cnt_mem[j_addr] <= ppc_pkg::COUNT_W'(j_q == '0);
		end else if (ctrl.mem_op == ppc_pkg::M_COUNT_WR) begin
			cnt_mem[j_addr] <= mod_res;
		end
		if (ctrl.mem_op == ppc_pkg::M_COUNT_RD) begin
			rd_a_q <= cnt_mem[j_addr];
			rd_b_q <= cnt_mem[jm_addr];
		end else if (q_rd_en) begin
			rd_a_q <= cnt_mem[q_addr];
		end
	end

endmodule

FILE: hw/rtl/prime_partition_counter_core.sv
// Channel   Direction  Handshake            Payload
// input     in         in_valid/in_ready    opcode, query_value
// output    out        out_valid/out_ready  partition_count, status
// config    in         cfg_wr_en            value_limit
//
// A good query shows its result through the table read, capture and result register; a query
// with an error status skips the table read. A build runs the microcode on one memory port
// pair: it clears entries 0 to L (L = built limit), sieves candidates, marking the multiples of
// each prime from its square, then runs the count pass for each prime p over entries p to L.
// Reset initialises control state, the built flag and limit and the configured limit only.
// The next input is taken while a result waits in the output register; a second result stalls it.
`include "prime_partition_counter_core_macros.svh"

module prime_partition_counter_core #(
	parameter int TABLE_SIZE = ppc_pkg::TABLE_SIZE_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [ppc_pkg::CFG_W-1:0]        value_limit,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             opcode,
	input  logic [ppc_pkg::CFG_W-1:0]        query_value,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [ppc_pkg::COUNT_W-1:0]      partition_count,
	output logic [ppc_pkg::STATUS_W-1:0]     status
);

	localparam int LIM_MAX = (1 << ppc_pkg::CFG_W) - 1;
	localparam int DEPTH   = ((TABLE_SIZE < LIM_MAX) ? TABLE_SIZE : LIM_MAX) + 1;
	localparam int AW      = $clog2(DEPTH);

	ppc_pkg::state_t   state_q;
	ppc_pkg::state_t   state_d;
	ppc_pkg::ctrl_t    ctrl;
	ppc_pkg::dp_stat_t dp_stat;

	logic [ppc_pkg::CFG_W-1:0]    value_limit_q;
	logic                         table_built_q;
	logic [AW-1:0]                built_limit_q;
	logic [AW-1:0]                lim;
	logic                         seq_start;
	logic                         seq_busy;
	logic                         seq_done;
	logic                         q_rd_en;
	logic [ppc_pkg::COUNT_W-1:0]  q_data;
	logic                         res_ld;
	logic [ppc_pkg::STATUS_W-1:0] res_status_d;
	logic [ppc_pkg::COUNT_W-1:0]  res_count_q;
	logic [ppc_pkg::STATUS_W-1:0] res_status_q;
	logic                         out_load;
	logic                         out_valid_q;
	logic [ppc_pkg::COUNT_W-1:0]  out_count_q;
	logic [ppc_pkg::STATUS_W-1:0] out_status_q;

	// Clamp the configured limit to the table
	assign lim = (32'(value_limit_q) > 32'(TABLE_SIZE)) ? AW'(TABLE_SIZE)
		: AW'(value_limit_q);

	ppc_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (seq_start),
		.stat   (dp_stat),
		.ctrl   (ctrl),
		.busy   (seq_busy),
		.done   (seq_done)
	);

	ppc_dpath #(
		.TABLE_SIZE (TABLE_SIZE)
	) u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.lim     (lim),
		.q_rd_en (q_rd_en),
		.q_addr  (AW'(query_value)),
		.q_data  (q_data),
		.stat    (dp_stat)
	);

	// Item control: accept one item, run it, park the result until the output slot frees
	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		seq_start    = 1'b0;
		q_rd_en      = 1'b0;
		res_ld       = 1'b0;
		res_status_d = ppc_pkg::STATUS_OK;
		out_load     = 1'b0;
		case (state_q)
			ppc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					res_ld = 1'b1;
					if (opcode == ppc_pkg::OP_BUILD) begin
						seq_start = 1'b1;
						state_d   = ppc_pkg::ST_BUILD;
					end else if (!table_built_q) begin
						res_status_d = ppc_pkg::STATUS_NOT_BUILT;
						state_d      = ppc_pkg::ST_RESULT;
					end else if (query_value > ppc_pkg::CFG_W'(built_limit_q)) begin
						res_status_d = ppc_pkg::STATUS_ABOVE_LIMIT;
						state_d      = ppc_pkg::ST_RESULT;
					end else begin
						q_rd_en = 1'b1;
						state_d = ppc_pkg::ST_QUERY;
					end
				end
			end
			ppc_pkg::ST_BUILD: begin
				if (seq_done) begin
					state_d = ppc_pkg::ST_RESULT;
				end
			end
			ppc_pkg::ST_QUERY: begin
				state_d = ppc_pkg::ST_RESULT;
			end
			ppc_pkg::ST_RESULT: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ppc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ppc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ppc_pkg::ST_IDLE;
			value_limit_q <= ppc_pkg::LIMIT_RESET;
			table_built_q <= 1'b0;
			built_limit_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				value_limit_q <= value_limit;
			end
			// Commit the build once the program finishes
			if (seq_done) begin
				table_built_q <= 1'b1;
				built_limit_q <= lim;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload: zero count on build and error, table data on a good query
	always_ff @(posedge clk) begin
		if (res_ld) begin
			res_count_q  <= '0;
			res_status_q <= res_status_d;
		end else if (state_q == ppc_pkg::ST_QUERY) begin
			res_count_q <= q_data;
		end
		if (out_load) begin
			out_count_q  <= res_count_q;
			out_status_q <= res_status_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign partition_count = out_count_q;
	assign status          = out_status_q;

	`PPC_ASSERT_IMP(a_done_in_build, clk, arst_n, seq_done, state_q == ppc_pkg::ST_BUILD, "build finish outside build")
	`PPC_ASSERT_IMP(a_build_busy, clk, arst_n, state_q == ppc_pkg::ST_BUILD && !seq_done, seq_busy, "sequencer idle during build")
	`PPC_ASSERT_NXT(a_built_sticky, clk, arst_n, table_built_q, table_built_q, "built flag dropped")
	`PPC_ASSERT_IMP(a_err_zero, clk, arst_n, out_valid_q && status != ppc_pkg::STATUS_OK, partition_count == '0, "error result with nonzero count")

endmodule
